[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the Hill cipher block.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/hc_pkg.sv]
// ---------------------------------------------------------------------------
// hc_pkg
// Types, constants and mod-26 arithmetic helpers for the Hill cipher block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hc_pkg;

  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 5;

  typedef logic [LETTER_W-1:0] letter_t;

  // Padding letter 'x' used to complete an odd trailing letter.
  localparam letter_t PAD_LETTER = 5'd23;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_A = 3'd0,
    CFG_KEY_B = 3'd1,
    CFG_KEY_C = 3'd2,
    CFG_KEY_D = 3'd3,
    CFG_MODE  = 3'd4
  } cfg_reg_t;

  // Active matrix for the datapath plus the error flag that goes with it.
  typedef struct packed {
    letter_t m00;
    letter_t m01;
    letter_t m10;
    letter_t m11;
    logic    err;
  } hc_key_t;

  // A completed letter pair as a row vector.
  typedef struct packed {
    letter_t p0;
    letter_t p1;
    logic    last;
  } hc_pair_t;

  // Fold a 5-bit value into 0..25.
  function automatic letter_t red26(input letter_t x);
    return (x >= 5'd26) ? letter_t'(x - 5'd26) : x;
  endfunction

  // x mod 26 for x < 2048: reciprocal multiply by 2521/65536 gives the exact
  // quotient over this range, then one multiply-subtract gives the remainder.
  function automatic letter_t mod26(input logic [10:0] x);
    logic [22:0] prod;
    logic [6:0]  q;
    logic [11:0] r;
    prod = 23'(x) * 23'd2521;
    q    = prod[22:16];
    r    = {1'b0, x} - (12'(q) * 12'd26);
    return r[LETTER_W-1:0];
  endfunction

  // (a*b + c*d) mod 26 for operands already in 0..25.
  function automatic letter_t dot26(input letter_t a, input letter_t b,
                                    input letter_t c, input letter_t d);
    logic [10:0] s;
    s = (11'(a) * 11'(b)) + (11'(c) * 11'(d));
    return mod26(s);
  endfunction

  // Additive inverse mod 26 for a value in 0..25.
  function automatic letter_t neg26(input letter_t x);
    return (x == '0) ? '0 : letter_t'(5'd26 - x);
  endfunction

  // Multiplicative inverse mod 26; zero when none exists.
  function automatic letter_t inv26(input letter_t x);
    letter_t r;
    case (x)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/hc_stream_if.sv]
// ---------------------------------------------------------------------------
// Hill cipher stream interfaces
// Valid/ready channels for incoming letters and outgoing cipher letters.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hc_in_if;
  logic           valid;
  logic           ready;
  logic [4:0]     letter;
  logic           text_end;

  modport source (output valid, output letter, output text_end, input ready);
  modport sink   (input valid, input letter, input text_end, output ready);
endinterface

interface hc_out_if;
  logic           valid;
  logic           ready;
  logic [4:0]     letter_out;
  logic           last;
  logic           key_error;

  modport source (output valid, output letter_out, output last, output key_error,
                  input ready);
  modport sink   (input valid, input letter_out, input last, input key_error,
                  output ready);
endinterface

[hdl/hc_key_unit.sv]
// ---------------------------------------------------------------------------
// hc_key_unit
// Key and mode registers, two-stage inverse key computation, matrix select.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hc_key_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [hc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                           mode,
  output logic                           settling,
  output hc_pkg::hc_key_t                key
);
  import hc_pkg::*;

  letter_t key_a, key_b, key_c, key_d;
  letter_t ka, kb, kc, kd;
  letter_t det, det_next;
  letter_t inv_a, inv_b, inv_c, inv_d;
  letter_t inv_a_next, inv_b_next, inv_c_next, inv_d_next;
  letter_t det_inv;
  logic    not_invertible, not_invertible_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_a <= 5'd1;
      key_b <= 5'd0;
      key_c <= 5'd0;
      key_d <= 5'd1;
      mode  <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_KEY_A: key_a <= cfg_data;
        CFG_KEY_B: key_b <= cfg_data;
        CFG_KEY_C: key_c <= cfg_data;
        CFG_KEY_D: key_d <= cfg_data;
        CFG_MODE:  mode  <= cfg_data[0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    ka = red26(key_a);
    kb = red26(key_b);
    kc = red26(key_c);
    kd = red26(key_d);
    // Offset by 26*26 keeps the difference non-negative.
    det_next = mod26((11'(ka) * 11'(kd)) + 11'd676 - (11'(kb) * 11'(kc)));
    det_inv             = inv26(det);
    not_invertible_next = (det_inv == '0);
    inv_a_next = dot26(det_inv, kd, 5'd0, 5'd0);
    inv_b_next = dot26(det_inv, neg26(kb), 5'd0, 5'd0);
    inv_c_next = dot26(det_inv, neg26(kc), 5'd0, 5'd0);
    inv_d_next = dot26(det_inv, ka, 5'd0, 5'd0);
  end

  // The determinant is registered from the key, and the inverse from the
  // determinant. The settling flag is raised in the cycle after a write so that
  // no letter is taken in while the inverse is still stale.
  always_ff @(posedge clk) begin
    if (rst) begin
      det            <= 5'd1;
      inv_a          <= 5'd1;
      inv_b          <= 5'd0;
      inv_c          <= 5'd0;
      inv_d          <= 5'd1;
      not_invertible <= 1'b0;
      settling       <= 1'b0;
    end else begin
      det            <= det_next;
      inv_a          <= inv_a_next;
      inv_b          <= inv_b_next;
      inv_c          <= inv_c_next;
      inv_d          <= inv_d_next;
      not_invertible <= not_invertible_next;
      settling       <= cfg_write;
    end
  end

  always_comb begin
    if (mode) begin
      key.m00 = inv_a;
      key.m01 = inv_b;
      key.m10 = inv_c;
      key.m11 = inv_d;
      key.err = not_invertible;
    end else begin
      key.m00 = ka;
      key.m01 = kb;
      key.m10 = kc;
      key.m11 = kd;
      key.err = 1'b0;
    end
  end

endmodule

[hdl/hc_pair_former.sv]
// ---------------------------------------------------------------------------
// hc_pair_former
// Gathers letters into pairs, pads or drops an odd end, registers the pair.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hc_pair_former (
  input  logic             clk,
  input  logic             rst,
  hc_in_if.sink            text_in,
  input  logic             mode,
  input  logic             hold,
  input  logic             pair_take,
  output logic             pair_valid,
  output hc_pkg::hc_pair_t pair
);
  import hc_pkg::*;

  letter_t  held_letter;
  logic     holding;
  logic     accept;
  logic     fire;
  letter_t  letter_r;
  hc_pair_t pair_next;

  assign text_in.ready = !hold && (!pair_valid || pair_take);
  assign accept        = text_in.valid && text_in.ready;
  assign letter_r      = red26(text_in.letter);

  // A pair completes on a second letter, or on a lone final letter when
  // encrypting; a lone final letter in decrypt mode is dropped.
  assign fire = accept && (holding || (text_in.text_end && !mode));

  always_comb begin
    if (holding) begin
      pair_next.p0   = held_letter;
      pair_next.p1   = letter_r;
      pair_next.last = text_in.text_end;
    end else begin
      pair_next.p0   = letter_r;
      pair_next.p1   = PAD_LETTER;
      pair_next.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holding    <= 1'b0;
      pair_valid <= 1'b0;
    end else begin
      if (accept) begin
        holding <= !holding && !text_in.text_end;
      end
      if (fire) begin
        pair_valid <= 1'b1;
      end else if (pair_take) begin
        pair_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !holding) begin
      held_letter <= letter_r;
    end
    if (fire) begin
      pair <= pair_next;
    end
  end

endmodule

[hdl/hc_result_queue.sv]
// ---------------------------------------------------------------------------
// hc_result_queue
// Matrix product mod 26, a two-pair result queue and the letter serializer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module hc_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             pair_valid,
  input  hc_pkg::hc_pair_t pair,
  input  hc_pkg::hc_key_t  key,
  output logic             space,
  hc_out_if.source         text_out
);
  import hc_pkg::*;

  letter_t    r0, r1;
  letter_t    e_r0   [2];
  letter_t    e_r1   [2];
  logic [1:0] e_last;
  logic [1:0] e_err;
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       phase;
  logic       push, pop;

  always_comb begin
    r0 = dot26(pair.p0, key.m00, pair.p1, key.m10);
    r1 = dot26(pair.p0, key.m01, pair.p1, key.m11);
    if (key.err) begin
      r0 = '0;
      r1 = '0;
    end
  end

  assign space = (count != 2'd2);
  assign push  = pair_valid && space;
  assign pop   = text_out.valid && text_out.ready && phase;

  assign text_out.valid      = (count != 2'd0);
  assign text_out.letter_out = phase ? e_r1[rd_ptr] : e_r0[rd_ptr];
  assign text_out.last       = phase && e_last[rd_ptr];
  assign text_out.key_error  = e_err[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      phase  <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (text_out.valid && text_out.ready) begin
        phase <= !phase;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      e_r0[wr_ptr]   <= r0;
      e_r1[wr_ptr]   <= r1;
      e_last[wr_ptr] <= pair.last;
      e_err[wr_ptr]  <= key.err;
    end
  end

  `ASSERT_CLK(a_count_range, clk, rst, count != 2'd3, "result queue count overflow")
  `ASSERT_CLK(a_phase_needs_entry, clk, rst, !phase || (count != 2'd0), "second letter with empty queue")
  `ASSERT_CLK(a_err_zero, clk, rst, !(text_out.valid && text_out.key_error) || (text_out.letter_out == '0), "key error with nonzero letter")
  `ASSERT_CLK(a_letter_range, clk, rst, !text_out.valid || (text_out.letter_out < 5'd26), "result letter out of range")

endmodule

[hdl/hill_cipher_2x2_mod26.sv]
// ---------------------------------------------------------------------------
// hill_cipher_2x2_mod26
// Streaming 2x2 Hill cipher over letter indices 0..25.
// ---------------------------------------------------------------------------
// The block takes one letter per item and gives two result items for every
// completed pair, so it sustains one input item per clock while the output
// side drains one letter per clock. Letters are paired as a row vector and
// multiplied mod 26 by the key [[key_a, key_b], [key_c, key_d]] in encrypt
// mode, or by its modular inverse in decrypt mode. A final odd letter is
// padded with 'x' when encrypting and silently dropped when decrypting. When
// the key determinant has no inverse mod 26, decrypted letters come out as 0
// with key_error set. The letter that completes a pair is registered in the
// pair register, and the product is then written into the result queue once
// the queue has space. The queue holds two pairs, so a stalled output still
// lets input flow until both entries and the pair register are full. After a
// configuration write the inverse key is registered through the determinant
// and inverse registers, so text_in.ready is held low in the cycle that
// follows each write; any pair completed after that uses the new inverse.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hill_cipher_2x2_mod26 (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [hc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hc_pkg::CFG_DATA_W-1:0]  cfg_data,
  hc_in_if.sink                          text_in,
  hc_out_if.source                       text_out
);
  import hc_pkg::*;

  logic     mode;
  logic     settling;
  hc_key_t  key;
  logic     pair_valid;
  hc_pair_t pair;
  logic     space;

  // Configuration registers and the precomputed inverse key.
  hc_key_unit u_key (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mode      (mode),
    .settling  (settling),
    .key       (key)
  );

  // Input side: pairs letters up and holds the completed pair in a register.
  // Input is held off while the inverse key settles after a write.
  hc_pair_former u_pair (
    .clk        (clk),
    .rst        (rst),
    .text_in    (text_in),
    .mode       (mode),
    .hold       (settling),
    .pair_take  (space),
    .pair_valid (pair_valid),
    .pair       (pair)
  );

  // Output side: matrix product into the queue, then one letter per item.
  hc_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .pair_valid (pair_valid),
    .pair       (pair),
    .key        (key),
    .space      (space),
    .text_out   (text_out)
  );

endmodule

[verif/tb_hill_cipher_2x2_mod26.sv]
// ---------------------------------------------------------------------------
// tb_hill_cipher_2x2_mod26
// Self-checking bench for the streaming 2x2 Hill cipher: a shadow cipher
// predicts every result letter, and randomized handshakes drive the stream.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hill_cipher_2x2_mod26;
  import hc_pkg::*;

  localparam int MODULUS       = 26;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int SETTLE_CYCLES = 6;     // pair register, queue write, margin
  localparam int STALL_LIMIT   = 1000;  // cycles with no accept on either side
  localparam int MAX_REPORTS   = 10;

  // One letter on its way into the block.
  typedef struct packed {
    letter_t letter;
    logic    text_end;
  } plain_item_t;

  // One letter on its way out of the block.
  typedef struct packed {
    letter_t letter_out;
    logic    last;
    logic    key_error;
  } cipher_letter_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hc_in_if  text_in ();
  hc_out_if text_out ();

  hill_cipher_2x2_mod26 uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .text_in   (text_in),
    .text_out  (text_out)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Letters waiting to be offered, and result letters the cipher still owes us.
  plain_item_t    letters_pending[$];
  cipher_letter_t letters_due[$];

  // Shadow copy of the key registers, the mode and the derived inverse key.
  letter_t key_mat[4];
  logic    decrypt_mode;
  int      inv_key[4];
  logic    key_singular;

  // Shadow of the open pair: the first letter waits here for its partner.
  letter_t first_letter;
  logic    pair_open;

  int   faults;
  int   idle_cycles;
  int   random_sent;
  int   send_wait;
  int   recv_wait;
  logic quiet_send;
  logic quiet_recv;

  // The inverse is det^-1 * adj(key) mod 26. When the determinant shares a
  // factor with 26 there is no inverse, and decrypted letters carry an error.
  function void rederive_inverse();
    int a, b, c, d, det, inv, x;
    a = int'(key_mat[CFG_KEY_A]) % MODULUS;
    b = int'(key_mat[CFG_KEY_B]) % MODULUS;
    c = int'(key_mat[CFG_KEY_C]) % MODULUS;
    d = int'(key_mat[CFG_KEY_D]) % MODULUS;
    det = (a * d - b * c) % MODULUS;
    if (det < 0) begin
      det += MODULUS;
    end
    inv = 0;
    for (x = 1; x < MODULUS; x++) begin
      if (inv == 0 && (det * x) % MODULUS == 1) begin
        inv = x;
      end
    end
    key_singular = (inv == 0);
    inv_key[0] = (inv * d) % MODULUS;
    inv_key[1] = (inv * ((MODULUS - b) % MODULUS)) % MODULUS;
    inv_key[2] = (inv * ((MODULUS - c) % MODULUS)) % MODULUS;
    inv_key[3] = (inv * a) % MODULUS;
  endfunction

  // Multiply the row vector (p0, p1) by the active matrix. The mode and key in
  // force right now are used, even if they changed while the pair was open.
  function void emit_pair(letter_t p0, letter_t p1, logic closes_text);
    int             m00, m01, m10, m11, v0, v1;
    logic           bad;
    cipher_letter_t res;
    v0 = int'(p0);
    v1 = int'(p1);
    if (decrypt_mode) begin
      m00 = inv_key[0];
      m01 = inv_key[1];
      m10 = inv_key[2];
      m11 = inv_key[3];
      bad = key_singular;
    end else begin
      m00 = int'(key_mat[CFG_KEY_A]);
      m01 = int'(key_mat[CFG_KEY_B]);
      m10 = int'(key_mat[CFG_KEY_C]);
      m11 = int'(key_mat[CFG_KEY_D]);
      bad = 1'b0;
    end
    res.letter_out = bad ? letter_t'(0) : letter_t'((v0 * m00 + v1 * m10) % MODULUS);
    res.last       = 1'b0;
    res.key_error  = bad;
    letters_due.push_back(res);
    res.letter_out = bad ? letter_t'(0) : letter_t'((v0 * m01 + v1 * m11) % MODULUS);
    res.last       = closes_text;
    letters_due.push_back(res);
  endfunction

  // Shadow cipher step for one accepted letter. A lone final letter is padded
  // with 'x' when encrypting; when decrypting it is dropped without a result.
  function void cipher_step(letter_t ltr, logic closes_text);
    if (pair_open) begin
      pair_open = 1'b0;
      emit_pair(first_letter, ltr, closes_text);
    end else if (!closes_text) begin
      first_letter = ltr;
      pair_open    = 1'b1;
    end else if (!decrypt_mode) begin
      emit_pair(ltr, PAD_LETTER, 1'b1);
    end
  endfunction

  // Gap before the next item or result; quiet stretches run with no gaps.
  function int draw_wait(logic quiet);
    return quiet ? 0 : int'($urandom_range(0, 3));
  endfunction

  function void log_fault(string what, cipher_letter_t want, cipher_letter_t got);
    if (faults < MAX_REPORTS) begin
      $display("%0t: %s: expected letter %0d last %0b error %0b, got letter %0d last %0b error %0b",
               $time, what, want.letter_out, want.last, want.key_error,
               got.letter_out, got.last, got.key_error);
    end
    faults++;
  endfunction

  // Input driver. The letter accepted at this edge goes through the shadow
  // cipher first; a new letter is then offered in the same step if its gap
  // has already run out, so valid is assigned exactly once per edge.
  always @(posedge clk) begin : drive_letters
    logic        show;
    plain_item_t nxt;
    if (rst) begin
      text_in.valid    <= 1'b0;
      text_in.letter   <= '0;
      text_in.text_end <= 1'b0;
      send_wait = 0;
    end else begin
      show = text_in.valid;
      if (text_in.valid && text_in.ready) begin
        cipher_step(text_in.letter, text_in.text_end);
        show = 1'b0;
      end
      if (!show) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (letters_pending.size() != 0) begin
          nxt = letters_pending.pop_front();
          text_in.letter   <= nxt.letter;
          text_in.text_end <= nxt.text_end;
          show = 1'b1;
          if ($urandom_range(0, 39) == 0) begin
            quiet_send = !quiet_send;
          end
          send_wait = draw_wait(quiet_send);
        end
      end
      text_in.valid <= show;
    end
  end

  // Output monitor. Every accepted result letter is held against the oldest
  // expectation; ready is then held low for a drawn gap, which may be empty.
  always @(posedge clk) begin : check_letters
    cipher_letter_t got;
    cipher_letter_t want;
    logic           take;
    if (rst) begin
      text_out.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (text_out.valid && text_out.ready) begin
        got.letter_out = text_out.letter_out;
        got.last       = text_out.last;
        got.key_error  = text_out.key_error;
        if (letters_due.size() == 0) begin
          log_fault("unexpected result", '0, got);
        end else begin
          want = letters_due.pop_front();
          if (got.letter_out !== want.letter_out || got.last !== want.last ||
              got.key_error !== want.key_error) begin
            log_fault("wrong result", want, got);
          end
        end
        if ($urandom_range(0, 39) == 0) begin
          quiet_recv = !quiet_recv;
        end
        recv_wait = draw_wait(quiet_recv);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      text_out.ready <= take;
    end
  end

  // Any accepted item on either side proves the block is still moving.
  always @(posedge clk) begin
    if (rst || (text_in.valid && text_in.ready) || (text_out.valid && text_out.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("%0t: no item accepted for %0d cycles", $time, STALL_LIMIT);
    $display("hill_cipher_2x2_mod26: mismatch");
    $finish;
  end

  task automatic queue_letter(letter_t ltr, logic closes_text);
    plain_item_t it;
    it.letter   = ltr;
    it.text_end = closes_text;
    letters_pending.push_back(it);
  endtask

  // Mostly proper letters, with the out-of-range codes 26..31 mixed in.
  function letter_t rand_letter();
    return ($urandom_range(0, 7) == 0) ? letter_t'($urandom_range(26, 31))
                                       : letter_t'($urandom_range(0, 25));
  endfunction

  function letter_t rand_key();
    case ($urandom_range(0, 9))
      0:       return letter_t'(0);
      1:       return letter_t'(25);
      2:       return letter_t'(31);
      3:       return letter_t'($urandom_range(26, 31));
      default: return letter_t'($urandom_range(0, 25));
    endcase
  endfunction

  // Wait until nothing is offered or owed, then give the block time to finish
  // any dropped trailing letter before registers change.
  task automatic drain();
    @(negedge clk);
    while (letters_pending.size() != 0 || text_in.valid || letters_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write per edge; the shadow follows at once since the block
  // is idle while registers change.
  task automatic program_reg(cfg_reg_t idx, letter_t val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_MODE) begin
      decrypt_mode = val[0];
    end else begin
      key_mat[idx] = val;
    end
    rederive_inverse();
  endtask

  task automatic end_program();
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Mode writes carry random upper bits; only bit 0 selects the mode.
  task automatic program_mode(logic m);
    program_reg(CFG_MODE, {letter_t'($urandom_range(0, 15)) << 1} | letter_t'(m));
  endtask

  task automatic program_key(letter_t a, letter_t b, letter_t c, letter_t d, logic m);
    program_reg(CFG_KEY_A, a);
    program_reg(CFG_KEY_B, b);
    program_reg(CFG_KEY_C, c);
    program_reg(CFG_KEY_D, d);
    program_mode(m);
    end_program();
  endtask

  initial begin : stimulus
    int phase_len;
    int phase_cnt;
    int text_len;
    int i;
    logic broken;

    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    text_in.valid    = 1'b0;
    text_in.letter   = '0;
    text_in.text_end = 1'b0;
    text_out.ready   = 1'b0;
    faults           = 0;
    idle_cycles      = 0;
    random_sent      = 0;
    send_wait        = 0;
    recv_wait        = 0;
    quiet_send       = 1'b0;
    quiet_recv       = 1'b0;

    // Reset state: identity key, encrypt mode, no open pair.
    key_mat[CFG_KEY_A] = 5'd1;
    key_mat[CFG_KEY_B] = 5'd0;
    key_mat[CFG_KEY_C] = 5'd0;
    key_mat[CFG_KEY_D] = 5'd1;
    decrypt_mode       = 1'b0;
    first_letter       = '0;
    pair_open          = 1'b0;
    rederive_inverse();

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset key passes letters through. Extremes of the letter field, the
    // out-of-range codes 31 and 26, and an odd final letter that gets padded with 'x'.
    queue_letter(5'd0, 1'b0);
    queue_letter(5'd25, 1'b0);
    queue_letter(5'd31, 1'b0);
    queue_letter(5'd26, 1'b1);
    queue_letter(5'd13, 1'b1);
    drain();

    // An invertible key while encrypting. The phase ends with a letter held
    // in an open pair so that the mode changes before the pair completes.
    program_key(5'd3, 5'd3, 5'd2, 5'd5, 1'b0);
    queue_letter(5'd7, 1'b0);
    queue_letter(5'd4, 1'b0);
    queue_letter(5'd25, 1'b1);
    queue_letter(5'd19, 1'b0);
    drain();

    // Same key decrypting: the held pair completes in decrypt mode, and a lone
    // final letter is dropped so no result of that text carries last.
    program_mode(1'b1);
    end_program();
    queue_letter(5'd8, 1'b1);
    queue_letter(5'd2, 1'b0);
    queue_letter(5'd9, 1'b0);
    queue_letter(5'd17, 1'b1);
    drain();

    // Determinant zero: decrypt flags the key error and zeroes both letters.
    program_key(5'd2, 5'd4, 5'd1, 5'd2, 1'b1);
    queue_letter(5'd5, 1'b0);
    queue_letter(5'd6, 1'b1);
    queue_letter(5'd1, 1'b0);
    queue_letter(5'd12, 1'b0);
    drain();

    // The same singular key in encrypt mode never raises the error.
    program_mode(1'b0);
    end_program();
    queue_letter(5'd5, 1'b0);
    queue_letter(5'd6, 1'b1);
    drain();

    // Out-of-range key codes act as their value mod 26.
    program_key(5'd31, 5'd0, 5'd0, 5'd31, 1'b1);
    queue_letter(5'd31, 1'b0);
    queue_letter(5'd31, 1'b1);
    drain();

    // An all-zero key maps every pair to 'a'.
    program_key(5'd0, 5'd0, 5'd0, 5'd0, 1'b0);
    queue_letter(5'd25, 1'b0);
    queue_letter(5'd25, 1'b1);
    drain();

    // Random phases: each gets a fresh key (or only a mode flip, which lands
    // in the middle of any pair left open), then a run of texts. Most texts
    // are well formed; some are cut short and some items are plain noise.
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        program_mode(!decrypt_mode);
        end_program();
      end else begin
        program_key(rand_key(), rand_key(), rand_key(), rand_key(),
                    logic'($urandom_range(0, 1)));
      end
      phase_len = $urandom_range(20, 80);
      phase_cnt = 0;
      while (phase_cnt < phase_len) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_letter(rand_letter(), logic'($urandom_range(0, 1)));
          phase_cnt++;
        end else begin
          text_len = $urandom_range(1, 12);
          broken   = ($urandom_range(0, 7) == 0);
          for (i = 0; i < text_len; i++) begin
            queue_letter(rand_letter(), (i == text_len - 1) && !broken);
          end
          phase_cnt += text_len;
        end
      end
      random_sent += phase_cnt;
      drain();
    end

    if (faults == 0) begin
      $display("hill_cipher_2x2_mod26: match");
    end else begin
      $display("hill_cipher_2x2_mod26: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/hc_pkg.sv
hdl/hc_stream_if.sv
hdl/hc_key_unit.sv
hdl/hc_pair_former.sv
hdl/hc_result_queue.sv
hdl/hill_cipher_2x2_mod26.sv
verif/tb_hill_cipher_2x2_mod26.sv
